// ===== design/fea_pkg.sv =====
// Shared types and constants for the forward elimination block.
package fea_pkg;

    localparam int unsigned VALUE_W     = 32;
    localparam int unsigned ORDER_W     = 3;
    localparam int unsigned FRAC_BITS   = 16;
    localparam int unsigned DIVIDEND_W  = VALUE_W + FRAC_BITS;
    localparam int unsigned DIV_CNT_W   = 6;
    localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd3;
    localparam logic [ORDER_W-1:0] ORDER_MIN   = 3'd2;
    localparam logic [0:0] REG_ORDER = 1'b0;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
        logic [ORDER_W-1:0]        order;
    } queue_entry_t;

    typedef struct packed {
        logic                         start;
        logic signed [DIVIDEND_W-1:0] dividend;
        logic signed [VALUE_W-1:0]    divisor;
    } div_req_t;

    typedef struct packed {
        logic                      done;
        logic signed [VALUE_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== design/fea_front.sv =====
// Front end: takes input beats, counts the load and tags the last element.
module fea_front #(
    parameter int unsigned MAX_ORDER = 7
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [fea_pkg::VALUE_W-1:0]  s_element_value,
    input  logic [fea_pkg::ORDER_W-1:0]         order,
    input  logic                                q_full,
    output logic                                q_push,
    output fea_pkg::queue_entry_t               q_entry
);
    import fea_pkg::*;

    localparam int unsigned DEPTH = MAX_ORDER * (MAX_ORDER + 1);
    localparam int unsigned CW    = $clog2(DEPTH + 1);

    logic [CW-1:0]      count_reg;
    logic [ORDER_W-1:0] n_eff;
    logic [CW-1:0]      total;
    logic [CW-1:0]      count_inc;
    logic               last;

    always_comb begin
        if (order < ORDER_MIN) begin
            n_eff = ORDER_MIN;
        end else if (32'(order) > MAX_ORDER) begin
            n_eff = ORDER_W'(MAX_ORDER);
        end else begin
            n_eff = order;
        end
        total     = CW'(CW'(n_eff) * (CW'(n_eff) + CW'(1)));
        count_inc = count_reg + CW'(1);
        last      = (count_inc >= total);
    end

    assign s_ready        = !q_full;
    assign q_push         = s_valid && s_ready;
    assign q_entry.value  = s_element_value;
    assign q_entry.last   = last;
    assign q_entry.order  = n_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (q_push) begin
            count_reg <= last ? '0 : count_inc;
        end
    end

endmodule

// ===== design/fea_queue.sv =====
// Small FIFO between the front end and the elimination engine.
module fea_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  fea_pkg::queue_entry_t push_entry,
    output logic                  full,
    input  logic                  pop,
    output logic                  pop_valid,
    output fea_pkg::queue_entry_t pop_entry
);
    import fea_pkg::*;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned PW     = $clog2(QDEPTH);

    queue_entry_t    slot_reg [QDEPTH];
    logic [PW-1:0]   wptr_reg;
    logic [PW-1:0]   rptr_reg;
    logic [PW:0]     fill_reg;
    logic            do_push;
    logic            do_pop;

    assign full      = (fill_reg == (PW+1)'(QDEPTH));
    assign pop_valid = (fill_reg != '0);
    assign pop_entry = slot_reg[rptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wptr_reg] <= push_entry;
        end
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end else begin
            if (do_push) begin
                wptr_reg <= wptr_reg + PW'(1);
            end
            if (do_pop) begin
                rptr_reg <= rptr_reg + PW'(1);
            end
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + (PW+1)'(1);
            end else if (do_pop && !do_push) begin
                fill_reg <= fill_reg - (PW+1)'(1);
            end
        end
    end

endmodule

// ===== design/fea_div.sv =====
// Radix-2 restoring divider: Q16.16 quotient, truncated, saturated.
module fea_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  fea_pkg::div_req_t req,
    output fea_pkg::div_rsp_t rsp
);
    import fea_pkg::*;

    logic [VALUE_W-1:0]    rem_reg;
    logic [DIVIDEND_W-1:0] dq_reg;
    logic [VALUE_W-1:0]    dv_reg;
    logic                  neg_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [VALUE_W:0]      shifted;
    logic [VALUE_W:0]      trial;
    logic [DIVIDEND_W-1:0] dd_abs;
    logic [VALUE_W-1:0]    dv_abs;

    always_comb begin
        shifted = {rem_reg, dq_reg[DIVIDEND_W-1]};
        trial   = shifted - {1'b0, dv_reg};
        dd_abs  = req.dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-req.dividend)
                                             : DIVIDEND_W'(req.dividend);
        dv_abs  = req.divisor[VALUE_W-1] ? VALUE_W'(-req.divisor)
                                         : VALUE_W'(req.divisor);
    end

    // saturate the magnitude quotient back to signed Q16.16
    always_comb begin
        rsp.done = done_reg;
        if (!neg_reg) begin
            if (dq_reg > DIVIDEND_W'(32'h7FFF_FFFF)) begin
                rsp.quotient = 32'sh7FFF_FFFF;
            end else begin
                rsp.quotient = dq_reg[VALUE_W-1:0];
            end
        end else begin
            if (dq_reg > DIVIDEND_W'(32'h8000_0000)) begin
                rsp.quotient = 32'sh8000_0000;
            end else begin
                rsp.quotient = VALUE_W'(-dq_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                rem_reg  <= '0;
                dq_reg   <= dd_abs;
                dv_reg   <= dv_abs;
                neg_reg  <= req.dividend[DIVIDEND_W-1] ^ req.divisor[VALUE_W-1];
                cnt_reg  <= DIV_CNT_W'(DIVIDEND_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (!trial[VALUE_W]) begin
                    rem_reg <= trial[VALUE_W-1:0];
                end else begin
                    rem_reg <= shifted[VALUE_W-1:0];
                end
                dq_reg  <= {dq_reg[DIVIDEND_W-2:0], !trial[VALUE_W]};
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== design/fea_back.sv =====
// Back end: matrix memory, elimination sequencer and result output register.
module fea_back #(
    parameter int unsigned MAX_ORDER = 7
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                q_valid,
    input  fea_pkg::queue_entry_t               q_entry,
    output logic                                q_pop,
    output fea_pkg::div_req_t                   div_req,
    input  fea_pkg::div_rsp_t                   div_rsp,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [fea_pkg::VALUE_W-1:0]  m_result_value,
    output logic [fea_pkg::ORDER_W-1:0]         m_row_index,
    output logic [fea_pkg::ORDER_W-1:0]         m_column_index,
    output logic                                m_final_element,
    output logic                                m_zero_pivot
);
    import fea_pkg::*;

    localparam int unsigned DEPTH = MAX_ORDER * (MAX_ORDER + 1);
    localparam int unsigned AW    = $clog2(DEPTH);

    typedef enum logic [3:0] {
        S_LOAD, S_PRD, S_PCHK, S_DIV, S_RDK, S_MUL, S_WR, S_ERD, S_EOUT, S_EWAIT
    } state_t;

    state_t state_reg;

    logic signed [VALUE_W-1:0] mem [DEPTH];
    logic signed [VALUE_W-1:0] rdata_a_reg;
    logic signed [VALUE_W-1:0] rdata_b_reg;
    logic [AW-1:0]             raddr_a;
    logic [AW-1:0]             raddr_b;
    logic                      mem_we;
    logic [AW-1:0]             mem_waddr;
    logic signed [VALUE_W-1:0] mem_wdata;

    logic [AW:0]               ptr_reg;
    logic [ORDER_W-1:0]        n_reg;
    logic [ORDER_W-1:0]        j_reg;
    logic [ORDER_W-1:0]        r_reg;
    logic [ORDER_W-1:0]        k_reg;
    logic signed [VALUE_W-1:0] mult_reg;
    logic signed [63:0]        prod_reg;
    logic signed [VALUE_W-1:0] rb_reg;
    logic                      err_reg;
    logic [AW-1:0]             e_idx_reg;
    logic [ORDER_W-1:0]        e_row_reg;
    logic [ORDER_W-1:0]        e_col_reg;
    logic                      m_valid_reg;

    logic [ORDER_W:0]          w;
    logic signed [63:0]        prod_sh;
    logic signed [48:0]        diff;
    logic signed [VALUE_W-1:0] diff_sat;
    logic                      row_last;
    logic                      pivot_last;

    function automatic logic [AW-1:0] lin_addr(input logic [ORDER_W-1:0] row,
                                               input logic [ORDER_W:0]   width,
                                               input logic [ORDER_W-1:0] col);
        logic [6:0] lin;
        lin = 7'(row) * 7'(width) + 7'(col);
        return lin[AW-1:0];
    endfunction

    assign w          = {1'b0, n_reg} + (ORDER_W+1)'(1);
    assign row_last   = (r_reg == n_reg - ORDER_W'(1));
    assign pivot_last = (j_reg + ORDER_W'(2) == n_reg);

    // A[r][k] - floor(A[j][k]*m / 2^16), saturated
    always_comb begin
        prod_sh = prod_reg >>> FRAC_BITS;
        diff    = 49'(rb_reg) - prod_sh[48:0];
        if (diff > 49'sh0_7FFF_FFFF) begin
            diff_sat = 32'sh7FFF_FFFF;
        end else if (diff < -49'sh0_8000_0000) begin
            diff_sat = 32'sh8000_0000;
        end else begin
            diff_sat = diff[VALUE_W-1:0];
        end
    end

    always_comb begin
        raddr_a   = '0;
        raddr_b   = '0;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = q_entry.value;
        q_pop     = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = {rdata_b_reg, {FRAC_BITS{1'b0}}};
        div_req.divisor  = rdata_a_reg;
        case (state_reg)
            S_LOAD: begin
                q_pop     = q_valid;
                mem_we    = q_valid && (ptr_reg < (AW+1)'(DEPTH));
                mem_waddr = ptr_reg[AW-1:0];
            end
            S_PRD: begin
                raddr_a = lin_addr(j_reg, w, j_reg);
                raddr_b = lin_addr(r_reg, w, j_reg);
            end
            S_PCHK: begin
                div_req.start = (rdata_a_reg != '0);
            end
            S_RDK: begin
                raddr_a = lin_addr(j_reg, w, k_reg);
                raddr_b = lin_addr(r_reg, w, k_reg);
            end
            S_WR: begin
                mem_we    = 1'b1;
                mem_waddr = lin_addr(r_reg, w, k_reg);
                mem_wdata = diff_sat;
            end
            S_ERD: begin
                raddr_a = e_idx_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_LOAD;
            ptr_reg     <= '0;
            n_reg       <= ORDER_RESET;
            err_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            j_reg       <= '0;
            r_reg       <= '0;
            k_reg       <= '0;
            e_idx_reg   <= '0;
            e_row_reg   <= '0;
            e_col_reg   <= '0;
        end else begin
            case (state_reg)
                S_LOAD: begin
                    if (q_valid) begin
                        if (q_entry.last) begin
                            ptr_reg   <= '0;
                            n_reg     <= q_entry.order;
                            err_reg   <= 1'b0;
                            j_reg     <= '0;
                            r_reg     <= ORDER_W'(1);
                            state_reg <= S_PRD;
                        end else begin
                            ptr_reg <= ptr_reg + (AW+1)'(1);
                        end
                    end
                end
                S_PRD: begin
                    state_reg <= S_PCHK;
                end
                S_PCHK: begin
                    if (rdata_a_reg == '0) begin
                        // zero pivot: row stays as it is
                        err_reg <= 1'b1;
                        if (!row_last) begin
                            r_reg     <= r_reg + ORDER_W'(1);
                            state_reg <= S_PRD;
                        end else if (!pivot_last) begin
                            j_reg     <= j_reg + ORDER_W'(1);
                            r_reg     <= j_reg + ORDER_W'(2);
                            state_reg <= S_PRD;
                        end else begin
                            e_idx_reg <= '0;
                            e_row_reg <= '0;
                            e_col_reg <= '0;
                            state_reg <= S_ERD;
                        end
                    end else begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        mult_reg  <= div_rsp.quotient;
                        k_reg     <= j_reg;
                        state_reg <= S_RDK;
                    end
                end
                S_RDK: begin
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    prod_reg  <= rdata_a_reg * mult_reg;
                    rb_reg    <= rdata_b_reg;
                    state_reg <= S_WR;
                end
                S_WR: begin
                    if (k_reg != n_reg) begin
                        k_reg     <= k_reg + ORDER_W'(1);
                        state_reg <= S_RDK;
                    end else if (!row_last) begin
                        r_reg     <= r_reg + ORDER_W'(1);
                        state_reg <= S_PRD;
                    end else if (!pivot_last) begin
                        j_reg     <= j_reg + ORDER_W'(1);
                        r_reg     <= j_reg + ORDER_W'(2);
                        state_reg <= S_PRD;
                    end else begin
                        e_idx_reg <= '0;
                        e_row_reg <= '0;
                        e_col_reg <= '0;
                        state_reg <= S_ERD;
                    end
                end
                S_ERD: begin
                    state_reg <= S_EOUT;
                end
                S_EOUT: begin
                    m_result_value  <= rdata_a_reg;
                    m_row_index     <= e_row_reg;
                    m_column_index  <= e_col_reg;
                    m_final_element <= (e_row_reg == n_reg - ORDER_W'(1)) &&
                                       (e_col_reg == n_reg);
                    m_zero_pivot    <= err_reg;
                    m_valid_reg     <= 1'b1;
                    state_reg       <= S_EWAIT;
                end
                S_EWAIT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        e_idx_reg   <= e_idx_reg + AW'(1);
                        if (m_final_element) begin
                            state_reg <= S_LOAD;
                        end else begin
                            if (e_col_reg == n_reg) begin
                                e_col_reg <= '0;
                                e_row_reg <= e_row_reg + ORDER_W'(1);
                            end else begin
                                e_col_reg <= e_col_reg + ORDER_W'(1);
                            end
                            state_reg <= S_ERD;
                        end
                    end
                end
                default: begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;

    a_valid_only_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (state_reg == S_EWAIT))
        else $error("result beat shown outside output wait");

    a_final_on_last_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_final_element) |-> (m_row_index == n_reg - ORDER_W'(1)))
        else $error("final beat not on last row");

    a_div_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == S_DIV))
        else $error("divider finished while not awaited");

    a_no_pop_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (state_reg == S_LOAD) && !m_valid_reg)
        else $error("queue popped during elimination");

endmodule

// ===== design/forward_elimination_augmented_top.sv =====
// Top level of the forward elimination block: config register and wiring.
//
// Usage:
//  - Input channel (s_valid/s_ready, s_element_value): one Q16.16 element
//    per beat, row-major, order*(order+1) beats make one augmented matrix.
//  - Result channel (m_valid/m_ready, m_*): the upper-triangular matrix,
//    row by row, one element per beat; m_final_element marks the last beat,
//    m_zero_pivot is high on every beat if a pivot was zero.
//  - APB port: register 0 at address 0 holds order (reset 3, clamped to 2..7).
//  - Loading: the front end takes one element per cycle into a 4-entry
//    queue while it is not full; the back end writes one element per cycle
//    into the matrix RAM while the queue is not empty.
//  - Elimination: per (pivot, row) pair setup, the bit-serial divider, then
//    per updated column: read, multiply, write back via one RAM write port.
//  - Output: each beat is read, registered and held until m_ready; a stalled
//    receiver holds the back end, while the front end keeps filling the queue.
//  - Reset (aresetn low, synchronous) clears the load count, the queue,
//    the sequencer and m_valid; the matrix RAM is not cleared.
module forward_elimination_augmented_top #(
    parameter int unsigned MAX_ORDER = 7
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input beats
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [fea_pkg::VALUE_W-1:0]  s_element_value,
    // result beats
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [fea_pkg::VALUE_W-1:0]  m_result_value,
    output logic [fea_pkg::ORDER_W-1:0]         m_row_index,
    output logic [fea_pkg::ORDER_W-1:0]         m_column_index,
    output logic                                m_final_element,
    output logic                                m_zero_pivot,
    // config port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import fea_pkg::*;

    logic [ORDER_W-1:0] order_reg;
    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               q_valid;
    queue_entry_t       push_entry;
    queue_entry_t       pop_entry;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    assign pready = 1'b1;

    // order register, word 0; higher word reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg <= ORDER_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_ORDER)) begin
            order_reg <= pwdata[ORDER_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_ORDER) ? {{(32-ORDER_W){1'b0}}, order_reg} : '0;

    fea_front #(.MAX_ORDER(MAX_ORDER)) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_element_value (s_element_value),
        .order           (order_reg),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_entry         (push_entry)
    );

    fea_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_entry  (pop_entry)
    );

    fea_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    fea_back #(.MAX_ORDER(MAX_ORDER)) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_entry         (pop_entry),
        .q_pop           (q_pop),
        .div_req         (div_req),
        .div_rsp         (div_rsp),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_value  (m_result_value),
        .m_row_index     (m_row_index),
        .m_column_index  (m_column_index),
        .m_final_element (m_final_element),
        .m_zero_pivot    (m_zero_pivot)
    );

endmodule
